@@ src/pwl_pkg.sv @@
// package for the piecewise linear interpolator
// types, constants and command/status codes; no dependencies
`default_nettype none
package pwl_pkg;
	localparam int TABLE_DEPTH_DEF = 64;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int IDX_W = 6;
	localparam int CNT_W = 7;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_INSIDE = 2'd0,
		ST_BELOW  = 2'd1,
		ST_ABOVE  = 2'd2,
		ST_ZERO   = 2'd3
	} status_t;
endpackage
`default_nettype wire

@@ src/pwl_ram.sv @@
// generic single-port ram with registered read
// no dependencies
`default_nettype none
module pwl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

@@ src/pwl_front.sv @@
// front end: accepts items and queues them for the engine
// depends on pwl_pkg
`default_nettype none
module pwl_front #(
	parameter int W = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   in_cmd,
	input  wire logic [pwl_pkg::IDX_W-1:0] in_idx,
	input  wire logic [W-1:0]           in_ex,
	input  wire logic [W-1:0]           in_ey,
	input  wire logic [W-1:0]           in_qx,
	output logic                        q_valid,
	input  wire logic                   q_ready,
	output logic                        q_cmd,
	output logic [pwl_pkg::IDX_W-1:0]   q_idx,
	output logic [W-1:0]                q_ex,
	output logic [W-1:0]                q_ey,
	output logic [W-1:0]                q_qx
);
	import pwl_pkg::*;
	localparam int DW = 1 + IDX_W + 3 * W;
	logic [DW-1:0] buf_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	logic          push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign push = in_valid && in_ready;
	assign pop  = q_valid && q_ready;
	assign {q_cmd, q_idx, q_ex, q_ey, q_qx} = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= {in_cmd, in_idx, in_ex, in_ey, in_qx};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

@@ src/pwl_back.sv @@
// back end: table, segment search, multiply, serial divide, saturate
// depends on pwl_pkg and pwl_ram
`default_nettype none
module pwl_back #(
	parameter int DEPTH = 64,
	parameter int W = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [pwl_pkg::CNT_W-1:0] points_in_use,
	input  wire logic                      q_valid,
	output logic                           q_ready,
	input  wire logic                      q_cmd,
	input  wire logic [pwl_pkg::IDX_W-1:0] q_idx,
	input  wire logic [W-1:0]              q_ex,
	input  wire logic [W-1:0]              q_ey,
	input  wire logic [W-1:0]              q_qx,
	output logic                           o_valid,
	input  wire logic                      o_ready,
	output logic [W-1:0]                   o_value,
	output logic [pwl_pkg::IDX_W-1:0]      o_segment,
	output logic [1:0]                     o_status,
	output logic                           o_sat
);
	import pwl_pkg::*;
	localparam int AW = $clog2(DEPTH);
	localparam int PW = 2 * W + 2;
	localparam int QW = 2 * W + 4;
	localparam int DXW = W + 1;

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_RD0  = 11'b00000000010,
		S_RDL  = 11'b00000000100,
		S_CMPL = 11'b00000001000,
		S_RDS  = 11'b00000010000,
		S_CMPS = 11'b00000100000,
		S_RD1  = 11'b00001000000,
		S_RD2  = 11'b00010000000,
		S_MUL  = 11'b00100000000,
		S_DIV  = 11'b01000000000,
		S_OUT  = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [AW-1:0] addr;
	logic we;
	logic [W-1:0] rx, ry;
	logic [AW:0] n_q, i_q, m_q;
	logic signed [W-1:0] qx_q, x0_q, x1_q, y1_q;
	logic [1:0] st_q;
	logic [DXW-1:0] dy_q, dq_q, dx_q;
	logic neg_q;
	logic [PW-1:0] prod_q;
	logic [QW-1:0] quo_q;
	logic [DXW:0] rem_q;
	logic [7:0] bit_q;
	logic [CNT_W-1:0] pc;
	logic signed [DXW-1:0] sdy, sdq, sdx;
	logic [DXW:0] rsh, rsub;
	logic signed [W+1:0] sum;
	logic signed [W+1:0] ext_res;

	assign pc = points_in_use;

	always_comb begin
		addr = AW'(q_idx);
		we = 1'b0;
		case (state_q)
			S_IDLE: begin
				we = q_valid && (q_cmd == CMD_WRITE) && !o_valid
					&& ({{(AW+1){1'b0}}, q_idx} < (AW+IDX_W+1)'(DEPTH));
				addr = (q_valid && q_cmd == CMD_QUERY) ? '0 : AW'(q_idx);
			end
			S_RD0, S_RDL: addr = AW'(n_q - 1'b1);
			S_CMPL, S_RDS, S_CMPS: addr = i_q[AW-1:0];
			S_RD2: addr = AW'(m_q + 1'b1);
			default: addr = m_q[AW-1:0];
		endcase
	end

	pwl_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_x (
		.clk(clk), .we(we), .addr(addr), .wdata(q_ex), .rdata(rx));
	pwl_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_y (
		.clk(clk), .we(we), .addr(addr), .wdata(q_ey), .rdata(ry));

	assign q_ready = (state_q == S_IDLE) && !o_valid;
	assign rsh = {rem_q[DXW-1:0], quo_q[QW-1]};
	assign rsub = rsh - {1'b0, dx_q};
	assign ext_res = neg_q ? -$signed({2'b00, quo_q[W-1:0]}) : $signed({2'b00, quo_q[W-1:0]});
	assign sum = $signed({{2{y1_q[W-1]}}, y1_q}) + ext_res;
	assign sdy = $signed({ry[W-1], ry}) - $signed({y1_q[W-1], y1_q});
	assign sdq = $signed({qx_q[W-1], qx_q}) - $signed({x1_q[W-1], x1_q});
	assign sdx = $signed({rx[W-1], rx}) - $signed({x1_q[W-1], x1_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			o_valid <= 1'b0;
		end else begin
			if (o_valid && o_ready) o_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (q_valid && !o_valid) begin
					if (q_cmd == CMD_WRITE) begin
						o_valid <= 1'b1;
						o_value <= '0; o_segment <= '0; o_status <= ST_INSIDE; o_sat <= 1'b0;
					end else begin
						qx_q <= q_qx;
						n_q <= (pc < 7'd2) ? (AW+1)'(2)
							: ({{(AW+1){1'b0}}, pc} > (AW+CNT_W+1)'(DEPTH)) ? (AW+1)'(DEPTH)
							: (AW+1)'(pc);
						state_q <= S_RD0;
					end
				end
				S_RD0: begin
					x0_q <= rx;
					state_q <= S_RDL;
				end
				S_RDL: state_q <= S_CMPL;
				S_CMPL: begin
					if (qx_q <= x0_q) begin
						m_q <= '0;
						st_q <= (qx_q < x0_q) ? ST_BELOW : ST_INSIDE;
						state_q <= S_RD1;
					end else if (qx_q >= $signed(rx)) begin
						m_q <= n_q - 2'd2;
						st_q <= (qx_q > $signed(rx)) ? ST_ABOVE : ST_INSIDE;
						state_q <= S_RD1;
					end else begin
						st_q <= ST_INSIDE;
						i_q <= (AW+1)'(1);
						state_q <= S_RDS;
					end
				end
				S_RDS: state_q <= S_CMPS;
				S_CMPS: begin
					if (i_q < n_q - 1'b1 && $signed(rx) <= qx_q) begin
						i_q <= i_q + 1'b1;
						state_q <= S_RDS;
					end else begin
						m_q <= i_q - 1'b1;
						state_q <= S_RD1;
					end
				end
				S_RD1: state_q <= S_RD2;
				S_RD2: begin
					x1_q <= rx; y1_q <= ry;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (rx == x1_q) begin
						o_valid <= 1'b1;
						o_value <= y1_q; o_segment <= IDX_W'(m_q); o_status <= ST_ZERO;
						o_sat <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						dy_q <= sdy[DXW-1] ? DXW'(-sdy) : DXW'(sdy);
						dq_q <= sdq[DXW-1] ? DXW'(-sdq) : DXW'(sdq);
						dx_q <= sdx[DXW-1] ? DXW'(-sdx) : DXW'(sdx);
						neg_q <= sdy[DXW-1] ^ sdq[DXW-1] ^ sdx[DXW-1];
						bit_q <= '0;
						state_q <= S_DIV;
						prod_q <= '0;
					end
				end
				S_DIV: begin
					// first forms the product, then loads it as the dividend, then one quotient bit a cycle
					if (bit_q == 8'd0) begin
						prod_q <= PW'(dy_q * dq_q);
						bit_q <= 8'd1;
					end else if (bit_q == 8'd1) begin
						quo_q <= QW'(prod_q);
						rem_q <= '0;
						bit_q <= 8'd2;
					end else begin
						if (!rsub[DXW]) begin
							rem_q <= rsub;
							quo_q <= {quo_q[QW-2:0], 1'b1};
						end else begin
							rem_q <= rsh;
							quo_q <= {quo_q[QW-2:0], 1'b0};
						end
						bit_q <= bit_q + 1'b1;
						if (bit_q == 8'(QW + 1)) state_q <= S_OUT;
					end
				end
				S_OUT: begin
					o_valid <= 1'b1;
					o_segment <= IDX_W'(m_q);
					o_status <= st_q;
					if (quo_q[QW-1:W] != '0) begin
						o_sat <= 1'b1;
						o_value <= neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
					end else if (sum > $signed({3'b000, {(W-1){1'b1}}})) begin
						o_sat <= 1'b1;
						o_value <= {1'b0, {(W-1){1'b1}}};
					end else if (sum < -$signed({3'b001, {(W-1){1'b0}}})) begin
						o_sat <= 1'b1;
						o_value <= {1'b1, {(W-1){1'b0}}};
					end else begin
						o_sat <= 1'b0;
						o_value <= sum[W-1:0];
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ src/piecewise_linear_interpolator.sv @@
// piecewise linear interpolator with a breakpoint table in block ram
// up to two input items wait queued in front of the engine (pwl_front, pwl_back)
//
// s_axis: tdata carries entry_index, entry_x, entry_y, query_x; tuser is command
// (0 writes breakpoint, 1 queries). m_axis: tdata carries value, segment,
// status, saturated. points_in_use is written through cfg_we/cfg_wdata.
// a write result is registered when the engine takes the item from the queue. a query
// result follows the table reads, segment search, multiply and serial divide; the
// search walks at most one table entry fewer than points_in_use (clamped to 2 to
// TABLE_DEPTH), and a zero-width segment skips the divider.
// one item is in the engine at a time; the next starts once the result is taken.
// the output register holds a result until m_axis_tready, and the queue keeps
// accepting items while it stalls until its two slots are full.
// reset clears control state and sets points_in_use to 2; the table is
// undefined until written.
`default_nettype none
module piecewise_linear_interpolator #(
	parameter int TABLE_DEPTH = pwl_pkg::TABLE_DEPTH_DEF,
	parameter int VALUE_WIDTH = pwl_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [pwl_pkg::CNT_W-1:0] cfg_wdata,
	input  wire logic                     s_axis_tvalid,
	output logic                          s_axis_tready,
	// entry_index, entry_x, entry_y, query_x, zero pad
	input  wire logic [((pwl_pkg::IDX_W+3*VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	// command
	input  wire logic                     s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  wire logic                     m_axis_tready,
	// value, segment, status, saturated, zero pad
	output logic [((VALUE_WIDTH+pwl_pkg::IDX_W+3+7)/8)*8-1:0] m_axis_tdata
);
	import pwl_pkg::*;
	localparam int W = VALUE_WIDTH;
	localparam int ODW = ((W + IDX_W + 3 + 7) / 8) * 8;

	logic [CNT_W-1:0] piu_q;
	logic q_valid, q_ready, q_cmd;
	logic [IDX_W-1:0] q_idx, o_segment;
	logic [W-1:0] q_ex, q_ey, q_qx, o_value;
	logic [1:0] o_status;
	logic o_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			piu_q <= CNT_W'(2);
		end else if (cfg_we) begin
			piu_q <= cfg_wdata;
		end
	end

	pwl_front #(.W(W)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(s_axis_tuser),
		.in_idx(s_axis_tdata[IDX_W-1:0]),
		.in_ex(s_axis_tdata[IDX_W +: W]),
		.in_ey(s_axis_tdata[IDX_W+W +: W]),
		.in_qx(s_axis_tdata[IDX_W+2*W +: W]),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd), .q_idx(q_idx),
		.q_ex(q_ex), .q_ey(q_ey), .q_qx(q_qx));

	pwl_back #(.DEPTH(TABLE_DEPTH), .W(W)) u_back (
		.clk(clk), .arst_n(arst_n), .points_in_use(piu_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd), .q_idx(q_idx),
		.q_ex(q_ex), .q_ey(q_ey), .q_qx(q_qx),
		.o_valid(m_axis_tvalid), .o_ready(m_axis_tready), .o_value(o_value),
		.o_segment(o_segment), .o_status(o_status), .o_sat(o_sat));

	assign m_axis_tdata = ODW'({o_sat, o_status, o_segment, o_value});
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// testbench for the piecewise linear interpolator: breakpoint writes and queries,
// checked against a behavioral predictor of segment choice, extrapolation and saturation
// depends on pwl_pkg and piecewise_linear_interpolator
`timescale 1ns / 1ps
module tb;
	import pwl_pkg::*;

	localparam int DW = ((IDX_W + 3*32 + 7)/8)*8;
	localparam int RW = ((32 + IDX_W + 3 + 7)/8)*8;

	typedef struct packed {
		logic        saturated;
		status_t     status;
		logic [5:0]  segment;
		logic [31:0] value;
	} interp_result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [DW-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [RW-1:0] m_axis_tdata;

	piecewise_linear_interpolator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	logic signed [31:0] bp_x [64];
	logic signed [31:0] bp_y [64];
	logic [6:0] points_cfg;
	interp_result_t expected_q[$];
	int mismatches = 0, results_seen = 0, queries_sent = 0, writes_sent = 0;
	int sat_seen = 0;
	bit idle_on = 1;
	bit hold_sink = 0;

	function automatic interp_result_t interpolate(input logic signed [31:0] q);
		interp_result_t r;
		int n, m, i;
		logic signed [63:0] x1, x2, y1, y2, dx, dy, dq, res;
		logic [127:0] prod, quo;
		logic [63:0] mdx, mdy, mdq;
		bit neg;
		r = '0;
		r.status = ST_INSIDE;
		n = points_cfg < 2 ? 2 : (points_cfg > 64 ? 64 : points_cfg);
		if (q <= bp_x[0]) begin
			m = 0;
			if (q < bp_x[0]) r.status = ST_BELOW;
		end else if (q >= bp_x[n-1]) begin
			m = n - 2;
			if (q > bp_x[n-1]) r.status = ST_ABOVE;
		end else begin
			i = 1;
			while (i < n - 1 && bp_x[i] <= q) i++;
			m = i - 1;
		end
		x1 = bp_x[m]; x2 = bp_x[m+1]; y1 = bp_y[m]; y2 = bp_y[m+1];
		r.segment = 6'(m);
		if (x1 == x2) begin
			res = y1;
			r.status = ST_ZERO;
		end else begin
			dx = x2 - x1; dy = y2 - y1; dq = 64'(signed'(q)) - x1;
			neg = ((dy < 0) != (dq < 0)) != (dx < 0);
			mdx = dx < 0 ? -dx : dx;
			mdy = dy < 0 ? -dy : dy;
			mdq = dq < 0 ? -dq : dq;
			prod = {64'd0, mdy} * {64'd0, mdq};
			quo = prod / {64'd0, mdx};
			if (quo >= (128'd1 << 62)) begin
				res = neg ? -64'sd2147483648 : 64'sd2147483647;
				r.saturated = 1;
			end else begin
				res = y1 + (neg ? -$signed(quo[63:0]) : $signed(quo[63:0]));
				if (res > 64'sd2147483647) begin
					res = 64'sd2147483647; r.saturated = 1;
				end else if (res < -64'sd2147483648) begin
					res = -64'sd2147483648; r.saturated = 1;
				end
			end
		end
		r.value = res[31:0];
		return r;
	endfunction

	task automatic idle_gap();
		if (idle_on && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 9)) @(posedge clk);
	endtask

	task automatic send_item(input cmd_t cmd, input logic [5:0] idx,
			input logic [31:0] ex, input logic [31:0] ey, input logic [31:0] qx);
		interp_result_t r;
		s_axis_tvalid <= 1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= DW'({qx, ey, ex, idx});
		do @(posedge clk); while (!s_axis_tready);
		if (cmd == CMD_WRITE) begin
			bp_x[idx] = ex;
			bp_y[idx] = ey;
			r = '0;
			writes_sent++;
		end else begin
			r = interpolate(qx);
			queries_sent++;
		end
		expected_q.push_back(r);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic settle();
		s_axis_tvalid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic set_points(input int n);
		cfg_we <= 1;
		cfg_wdata <= CNT_W'(n);
		@(posedge clk);
		cfg_we <= 0;
		points_cfg = 7'(n);
	endtask

	// non-decreasing table with random spacing, spacing kept small or wide as the wide argument selects
	task automatic load_table(input int n, input bit wide);
		logic signed [31:0] x;
		logic [31:0] step;
		x = wide ? -32'sd2000000000 : $signed($urandom) >>> 4;
		for (int i = 0; i < n; i++) begin
			send_item(CMD_WRITE, 6'(i), x, $urandom, 0);
			step = wide ? 32'($urandom_range(1, 62500000))
				: 32'($urandom_range(0, 1 << $urandom_range(0, 20)));
			x = x + $signed(step);
		end
	endtask

	function automatic logic [31:0] pick_query(input int n);
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return bp_x[$urandom_range(0, n - 1)];
			2: return bp_x[$urandom_range(0, n - 1)] + $urandom_range(0, 3) - 1;
			default: return bp_x[0] + $urandom_range(0, 32'(bp_x[n-1] - bp_x[0]));
		endcase
	endfunction

	task automatic test_directed();
		set_points(2);
		send_item(CMD_WRITE, 0, 32'h8000_0000, 32'h8000_0000, 0);
		send_item(CMD_WRITE, 1, 32'h7fff_ffff, 32'h7fff_ffff, 0);
		send_item(CMD_QUERY, 0, 0, 0, 32'h8000_0000);
		send_item(CMD_QUERY, 0, 0, 0, 32'h7fff_ffff);
		send_item(CMD_QUERY, 0, 0, 0, 32'h0);
		send_item(CMD_WRITE, 0, 32'h0, 32'h7fff_ffff, 0);
		send_item(CMD_WRITE, 1, 32'h1, 32'h8000_0000, 0);
		send_item(CMD_QUERY, 0, 0, 0, 32'h7fff_ffff);
		send_item(CMD_QUERY, 0, 0, 0, 32'h8000_0000);
		send_item(CMD_WRITE, 1, 32'h0, 32'h1234_5678, 0);
		send_item(CMD_QUERY, 0, 0, 0, 32'h0);
		send_item(CMD_QUERY, 0, 0, 0, 32'h5);
		send_item(CMD_WRITE, 0, 32'h0001_0000, 32'h0003_0000, 0);
		send_item(CMD_WRITE, 1, 32'h0003_0000, 32'hfffd_0000, 0);
		send_item(CMD_QUERY, 0, 0, 0, 32'h0002_0001);
		send_item(CMD_QUERY, 0, 0, 0, 32'hffff_ffff);
		send_item(CMD_WRITE, 63, 32'hffff_ffff, 32'hffff_ffff, 0);
		settle();
	endtask

	task automatic test_points_in_use(input int n, input int count);
		int used;
		used = n < 2 ? 2 : (n > 64 ? 64 : n);
		set_points(n);
		load_table(used, $urandom_range(0, 1));
		for (int k = 0; k < count; k++)
			if ($urandom_range(0, 15) == 0)
				send_item(CMD_WRITE, 6'($urandom_range(0, used - 1)), pick_query(used),
					$urandom, 0);
			else
				send_item(CMD_QUERY, 0, 0, 0, pick_query(used));
		settle();
	endtask

	// outputs held off while items keep coming
	task automatic test_backpressure();
		set_points(8);
		load_table(8, 0);
		hold_sink = 1;
		fork
			begin
				repeat (2000) @(posedge clk);
				hold_sink = 0;
			end
			begin
				for (int k = 0; k < 30; k++) send_item(CMD_QUERY, 0, 0, 0, pick_query(8));
				s_axis_tvalid <= 0;
			end
		join
		settle();
	endtask

	always @(posedge clk) begin
		interp_result_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[40:0];
			results_seen++;
			sat_seen += got.saturated;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected item: %h", got);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: value %h/%h seg %0d/%0d st %0d/%0d sat %0d/%0d",
							want.value, got.value, want.segment, got.segment,
							want.status, got.status, want.saturated, got.saturated);
				end
			end
		end
	end

	initial begin
		int hold;
		forever begin
			@(posedge clk);
			if (hold_sink) m_axis_tready <= 0;
			else if (idle_on && hold == 0 && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 9);
				m_axis_tready <= 0;
			end else if (hold > 0) begin
				hold--;
				m_axis_tready <= hold == 0;
			end else m_axis_tready <= 1;
		end
	end

	initial begin
		points_cfg = 2;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_points_in_use(64, 120);
		test_points_in_use(3, 150);
		test_backpressure();
		for (int p = 0; p < 8; p++) test_points_in_use($urandom_range(2, 64), 120);
		test_points_in_use(127, 40);
		test_points_in_use(0, 40);
		idle_on = 0;
		test_points_in_use(16, 150);
		$display("%0d writes and %0d queries checked, %0d saturated results",
			writes_sent, queries_sent, sat_seen);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#40ms;
		$display("FAILURE");
		$finish;
	end
endmodule
